/* sv/imvd_pkg.sv */
// Shared types, field widths and codes for the iterated matrix-vector direction block.
`default_nettype none

package imvd_pkg;

  localparam int DIM_DEF         = 8;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;

  localparam int MODE_W    = 2;
  localparam int IDX_FLD_W = 3;
  localparam int ROW_W     = 12;
  localparam int ELEM_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  localparam logic [ROW_W-1:0] ROW_MAX = 12'hFFF;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_V = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STEP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_DIS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_U_DIS = 2'd2;

  localparam logic LIST_STATE = 1'b0;
  localparam logic LIST_INPUT = 1'b1;

  // Control that travels with one multiply-accumulate issue.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } iss_t;

  function automatic logic [ROW_W-1:0] sat_inc(input logic [ROW_W-1:0] c);
    logic [ROW_W-1:0] r;
    r = (c == ROW_MAX) ? ROW_MAX : c + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/imvd_lane.sv */
// One matrix store with its multiply-accumulate, rounding and saturation pipeline.
`default_nettype none

module imvd_lane #(
  parameter int DIM         = imvd_pkg::DIM_DEF,
  parameter int VALUE_WIDTH = imvd_pkg::VALUE_WIDTH_DEF,
  parameter int ADDR_W      = 6
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [ADDR_W-1:0]             wr_addr,
  input  wire signed [VALUE_WIDTH-1:0] wr_data,
  input  wire [ADDR_W-1:0]             rd_addr,
  input  wire signed [VALUE_WIDTH-1:0] cur_val,
  input  imvd_pkg::iss_t               iss,
  output logic                         res_valid,
  output logic signed [VALUE_WIDTH-1:0] res_value
);
  import imvd_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int PW    = 2 * VW;
  localparam int ACC_W = PW + $clog2(DIM + 1) + 1;
  localparam int SH_W  = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [VW-1:0] mem [DIM*DIM];
  logic signed [VW-1:0] rd_data_r;
  logic signed [VW-1:0] cur_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] rnd;
  logic [SH_W-1:0]         sh;
  logic [SH_W-VW:0]        sh_hi;
  logic                    fits;
  logic signed [VW-1:0]    sat_val;
  iss_t s1_r, s2_r, s3_r;
  logic signed [VW-1:0]    res_r;
  logic                    res_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    prod_ext = {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
    acc_base = s2_r.first ? '0 : acc_r;
    rnd      = acc_r + HALF;
    sh       = rnd[ACC_W-1:FRAC_BITS];
    sh_hi    = sh[SH_W-1:VW-1];
    fits     = (&sh_hi) | ~(|sh_hi);
    if (fits) begin
      sat_val = sh[VW-1:0];
    end else if (sh[SH_W-1]) begin
      sat_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    cur_r  <= cur_val;
    prod_r <= rd_data_r * cur_r;
    if (s2_r.valid) begin
      acc_r <= acc_base + prod_ext;
    end
    if (s3_r.valid && s3_r.last) begin
      res_r <= sat_val;
    end
  end

  // Control stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      s1_r        <= iss;
      s2_r        <= s1_r;
      s3_r        <= s2_r;
      res_valid_r <= s3_r.valid && s3_r.last;
    end
  end

  assign res_valid = res_valid_r;
  assign res_value = res_r;

endmodule

`default_nettype wire

/* sv/iterated_matrix_vector_directions.sv */
// Top level: sequencer, direction vector, row counters and result stream.
`default_nettype none

// Holds a transition matrix A and an input matrix B (both loaded already
// transposed, one entry per word, mode in in_tuser) in two synchronous
// memories with one write and one read port each, plus a current
// direction vector. A direction word is stored and then echoed as
// state-list row 0. A matrix entry word is written as it is accepted. A
// step word sweeps all n*n (row, column) pairs through both memories,
// one pair per cycle, each memory feeding its own multiply-accumulate
// pipeline of four stages; results are rounded half up to 16 fraction
// bits and saturated. The step then streams n state-list words and,
// unless input dynamics are disabled, n input-list words, one per cycle
// while out_tready is high; n is the clamped dimension in use. A step
// keeps the input closed through compute and output. Only one word is
// in work at a time: in_tready is high while the block is idle, also
// when a result still waits on the output. Write configuration only
// while idle. Row counters saturate at 4095.
module iterated_matrix_vector_directions #(
  parameter int DIM         = imvd_pkg::DIM_DEF,
  parameter int VALUE_WIDTH = imvd_pkg::VALUE_WIDTH_DEF,
  localparam int IN_DW  = ((2 * imvd_pkg::IDX_FLD_W + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((imvd_pkg::ROW_W + imvd_pkg::ELEM_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // in_tdata fields, lowest bit up: row, col, value
  input  wire [IN_DW-1:0]                  in_tdata,
  // in_tuser fields: mode
  input  wire [imvd_pkg::MODE_W-1:0]       in_tuser,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // out_tdata fields, lowest bit up: row_number, element, result_value
  output logic [OUT_DW-1:0]                out_tdata,
  // out_tuser fields: list_select
  output logic [0:0]                       out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  input  wire                              cfg_we,
  input  wire [imvd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [imvd_pkg::CFG_W-1:0]        cfg_wdata
);
  import imvd_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = (DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int CNT_W  = $clog2(DIM + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam logic [1:0] ST_ECHO = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [CFG_W-1:0] dim_r;
  logic             a_dis_r;
  logic             u_dis_r;
  logic [CNT_W-1:0] n_eff;

  logic signed [VW-1:0] cur_r [DIM];
  logic signed [VW-1:0] nxt_r [DIM];
  logic signed [VW-1:0] u_r   [DIM];

  logic [IDX_W-1:0] ii_r, jj_r, wr_i_r, e_r;
  logic             issuing_r;
  logic             list_r;
  logic [ROW_W-1:0] srow_r, urow_r;
  logic signed [VW-1:0] echo_val_r;
  logic [ELEM_W-1:0]    echo_col_r;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_sel_r;
  logic                 out_last_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [ELEM_W-1:0]    out_elem_r;
  logic signed [VW-1:0] out_val_r;

  // Input word unpack.
  logic [MODE_W-1:0]    in_mode;
  logic [IDX_FLD_W-1:0] in_row, in_col;
  logic signed [VW-1:0] in_value;
  logic                 in_acc;
  logic                 ld_in_range;
  logic                 col_in_range;
  logic [ADDR_W-1:0]    ld_addr, rd_addr;

  logic                 slot_free;
  logic                 jj_last, ii_last, wr_last, e_last;
  logic                 res_a_valid, res_b_valid;
  logic signed [VW-1:0] res_a_value, res_b_value;
  logic signed [VW-1:0] cur_sel;
  iss_t                 iss;

  assign in_mode  = in_tuser;
  assign in_row   = in_tdata[IDX_FLD_W-1:0];
  assign in_col   = in_tdata[2*IDX_FLD_W-1:IDX_FLD_W];
  assign in_value = in_tdata[2*IDX_FLD_W +: VW];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Clamp the dimension in use to 1..DIM.
  always_comb begin
    if (dim_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(dim_r) > DIM) begin
      n_eff = CNT_W'(DIM);
    end else begin
      n_eff = CNT_W'(dim_r);
    end
  end

  assign ld_in_range  = (32'(in_row) < DIM) && (32'(in_col) < DIM);
  assign col_in_range = (32'(in_col) < DIM);
  assign ld_addr      = ADDR_W'(32'(in_row) * DIM + 32'(in_col));
  assign rd_addr      = ADDR_W'(32'(ii_r) * DIM + 32'(jj_r));

  assign jj_last = (CNT_W'(jj_r) + 1'b1) == n_eff;
  assign ii_last = (CNT_W'(ii_r) + 1'b1) == n_eff;
  assign wr_last = (CNT_W'(wr_i_r) + 1'b1) == n_eff;
  assign e_last  = (CNT_W'(e_r) + 1'b1) == n_eff;

  assign cur_sel = cur_r[jj_r];

  always_comb begin
    iss.valid = (state_r == ST_CALC) && issuing_r;
    iss.first = (jj_r == '0);
    iss.last  = jj_last;
  end

  imvd_lane #(
    .DIM         (DIM),
    .VALUE_WIDTH (VW),
    .ADDR_W      (ADDR_W)
  ) u_lane_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc && (in_mode == MODE_LOAD_A) && ld_in_range),
    .wr_addr   (ld_addr),
    .wr_data   (in_value),
    .rd_addr   (rd_addr),
    .cur_val   (cur_sel),
    .iss       (iss),
    .res_valid (res_a_valid),
    .res_value (res_a_value)
  );

  imvd_lane #(
    .DIM         (DIM),
    .VALUE_WIDTH (VW),
    .ADDR_W      (ADDR_W)
  ) u_lane_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc && (in_mode == MODE_LOAD_B) && ld_in_range),
    .wr_addr   (ld_addr),
    .wr_data   (in_value),
    .rd_addr   (rd_addr),
    .cur_val   (cur_sel),
    .iss       (iss),
    .res_valid (res_b_valid),
    .res_value (res_b_value)
  );

  // Next-state decode.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_STEP)) begin
          state_nxt = ST_CALC;
        end else if (in_acc && (in_mode == MODE_LOAD_V) && col_in_range) begin
          state_nxt = ST_ECHO;
        end
      end
      ST_CALC: begin
        if (res_a_valid && wr_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free && e_last && (list_r || u_dis_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drop the output word once taken; load a new one when the slot frees in the output or echo state.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (((state_r == ST_OUT) || (state_r == ST_ECHO)) && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dim_r       <= CFG_W'(8);
      a_dis_r     <= 1'b0;
      u_dis_r     <= 1'b0;
      srow_r      <= '0;
      urow_r      <= '0;
      issuing_r   <= 1'b0;
      ii_r        <= '0;
      jj_r        <= '0;
      wr_i_r      <= '0;
      e_r         <= '0;
      list_r      <= LIST_STATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_DIM:   dim_r   <= cfg_wdata;
          REG_A_DIS: a_dis_r <= cfg_wdata[0];
          REG_U_DIS: u_dis_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_mode == MODE_STEP)) begin
            // State-list rows start at one past the count.
            srow_r    <= sat_inc(srow_r);
            issuing_r <= 1'b1;
            ii_r      <= '0;
            jj_r      <= '0;
            wr_i_r    <= '0;
          end else if (in_acc && (in_mode == MODE_LOAD_V) && col_in_range) begin
            srow_r <= '0;
            urow_r <= '0;
          end
        end
        ST_CALC: begin
          if (issuing_r) begin
            if (jj_last) begin
              jj_r <= '0;
              if (ii_last) begin
                issuing_r <= 1'b0;
              end else begin
                ii_r <= ii_r + 1'b1;
              end
            end else begin
              jj_r <= jj_r + 1'b1;
            end
          end
          if (res_a_valid) begin
            if (wr_last) begin
              e_r    <= '0;
              list_r <= LIST_STATE;
            end else begin
              wr_i_r <= wr_i_r + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            if (e_last) begin
              e_r <= '0;
              if (!list_r && !u_dis_r) begin
                list_r <= LIST_INPUT;
              end else if (!u_dis_r) begin
                urow_r <= sat_inc(urow_r);
              end
            end else begin
              e_r <= e_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Vector storage and output payload.
  always_ff @(posedge clk) begin
    if (in_acc && (in_mode == MODE_LOAD_V) && col_in_range) begin
      cur_r[IDX_W'(in_col)] <= in_value;
      echo_val_r            <= in_value;
      echo_col_r            <= in_col;
    end

    if (state_r == ST_CALC) begin
      // With A disabled, pass the current element through at the diagonal.
      if (issuing_r && a_dis_r && (jj_r == ii_r)) begin
        nxt_r[ii_r] <= cur_sel;
      end
      if (res_a_valid && !a_dis_r) begin
        nxt_r[wr_i_r] <= res_a_value;
      end
      if (res_b_valid) begin
        u_r[wr_i_r] <= res_b_value;
      end
    end

    if ((state_r == ST_OUT) && slot_free) begin
      out_sel_r  <= list_r;
      out_row_r  <= list_r ? urow_r : srow_r;
      out_elem_r <= ELEM_W'(e_r);
      out_val_r  <= list_r ? u_r[e_r] : nxt_r[e_r];
      out_last_r <= e_last && (list_r || u_dis_r);
      // Retire the step: the next vector becomes current.
      if (e_last && (list_r || u_dis_r)) begin
        for (int k = 0; k < DIM; k++) begin
          if (k < 32'(n_eff)) begin
            cur_r[k] <= nxt_r[k];
          end
        end
      end
    end

    if ((state_r == ST_ECHO) && slot_free) begin
      out_sel_r  <= LIST_STATE;
      out_row_r  <= '0;
      out_elem_r <= echo_col_r;
      out_val_r  <= echo_val_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sel_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DW'({out_val_r, out_elem_r, out_row_r});

endmodule

`default_nettype wire

/* sv/imvd_checker.sv */
// Port-level checker for the iterated matrix-vector direction block, with its bind.
`default_nettype none

module imvd_checker #(
  parameter int DIM         = imvd_pkg::DIM_DEF,
  parameter int VALUE_WIDTH = imvd_pkg::VALUE_WIDTH_DEF,
  localparam int IN_DW  = ((2 * imvd_pkg::IDX_FLD_W + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((imvd_pkg::ROW_W + imvd_pkg::ELEM_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input wire                           clk,
  input wire                           rst_n,
  input wire [IN_DW-1:0]               in_tdata,
  input wire [imvd_pkg::MODE_W-1:0]    in_tuser,
  input wire                           in_tvalid,
  input wire                           in_tready,
  input wire [OUT_DW-1:0]              out_tdata,
  input wire [0:0]                     out_tuser,
  input wire                           out_tlast,
  input wire                           out_tvalid,
  input wire                           out_tready
);
  import imvd_pkg::*;

  logic in_acc;
  logic in_col_ok;
  assign in_acc    = in_tvalid && in_tready;
  assign in_col_ok = 32'(in_tdata[2*IDX_FLD_W-1:IDX_FLD_W]) < DIM;

  // A waiting result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A step keeps the input closed on the next cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == MODE_STEP) |=> !in_tready)
    else $error("input open right after a step word");

  // Matrix loads never block the input.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ((in_tuser == MODE_LOAD_A) || (in_tuser == MODE_LOAD_B)) |=> in_tready)
    else $error("input closed after a matrix load");

  // A stored direction element is echoed before the next word.
  a_echo_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == MODE_LOAD_V) && in_col_ok |=> !in_tready)
    else $error("input open right after a direction load");

  // State-list row zero only comes from a single-word echo.
  a_row0_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == LIST_STATE) && (out_tdata[ROW_W-1:0] == '0)
      |-> out_tlast)
    else $error("state-list row zero word without last");

endmodule

bind iterated_matrix_vector_directions imvd_checker #(
  .DIM         (DIM),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_imvd_checker (.*);

`default_nettype wire
